### rtl/point_in_polygon_ray_parity_defines.svh
// assertion macros for the point in polygon block
`ifndef POINT_IN_POLYGON_RAY_PARITY_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_PARITY_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define PIPR_CHECK(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIPR_CHECK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pipr_pkg.sv
package pipr_pkg;

	localparam int MAX_EDGES  = 256;
	localparam int COORD_BITS = 16;
	localparam int ADDR_BITS  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CNT_BITS   = $clog2(MAX_EDGES + 1);

	// ray direction (sqrt2, sqrt3) in Q1.14
	localparam int DIR_BITS  = 16;
	localparam logic signed [DIR_BITS-1:0] RAY_DX = DIR_BITS'(23170);
	localparam logic signed [DIR_BITS-1:0] RAY_DY = DIR_BITS'(28378);

	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = DIFF_BITS + DIR_BITS;
	localparam int LIN_BITS   = PROD_BITS + 1;
	localparam int CPROD_BITS = 2 * DIFF_BITS;
	localparam int CRS_BITS   = CPROD_BITS + 1;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} seg_t;

	typedef struct packed {
		logic busy;
		logic hit_valid;
		logic hit;
	} cross_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_RESULT
	} state_t;

endpackage

### rtl/pipr_if.sv
interface pipr_in_if
	import pipr_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	coord_t     start_x;
	coord_t     start_y;
	coord_t     end_x;
	coord_t     end_y;
	coord_t     probe_x;
	coord_t     probe_y;

	modport source (
		output valid, cmd, start_x, start_y, end_x, end_y, probe_x, probe_y,
		input  ready
	);
	modport sink (
		input  valid, cmd, start_x, start_y, end_x, end_y, probe_x, probe_y,
		output ready
	);
endinterface

interface pipr_out_if
	import pipr_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                inside_res;
	logic [CNT_BITS-1:0] crossings;
	logic [CNT_BITS-1:0] edges_held;
	logic                overflowed;

	modport source (
		output valid, inside_res, crossings, edges_held, overflowed,
		input  ready
	);
	modport sink (
		input  valid, inside_res, crossings, edges_held, overflowed,
		output ready
	);
endinterface

### rtl/pipr_cross.sv
module pipr_cross
	import pipr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seg_valid,
	input  seg_t        seg,
	input  coord_t      px,
	input  coord_t      py,
	output cross_stat_t stat
);

	logic v_s2, v_s3, v_s4, v_s5;

	logic signed [DIFF_BITS-1:0] v1x_s2, v1y_s2, v2x_s2, v2y_s2;

	logic signed [PROD_BITS-1:0]  dx_v2y_s3, dy_v2x_s3, dx_v1y_s3, dy_v1x_s3;
	logic signed [CPROD_BITS-1:0] v2x_v1y_s3, v2y_v1x_s3;

	logic signed [LIN_BITS-1:0] den_s4, num_s4;
	logic signed [CRS_BITS-1:0] crs_s4;

	logic hit_s5;
	logic den_nz, crs_nz, num_pos, num_neg, hit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= seg_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// edge and probe vectors relative to the edge start
	always_ff @(posedge clk) begin
		v1x_s2 <= DIFF_BITS'(px) - DIFF_BITS'(seg.sx);
		v1y_s2 <= DIFF_BITS'(py) - DIFF_BITS'(seg.sy);
		v2x_s2 <= DIFF_BITS'(seg.ex) - DIFF_BITS'(seg.sx);
		v2y_s2 <= DIFF_BITS'(seg.ey) - DIFF_BITS'(seg.sy);
	end

	always_ff @(posedge clk) begin
		dx_v2y_s3  <= PROD_BITS'(RAY_DX) * PROD_BITS'(v2y_s2);
		dy_v2x_s3  <= PROD_BITS'(RAY_DY) * PROD_BITS'(v2x_s2);
		dx_v1y_s3  <= PROD_BITS'(RAY_DX) * PROD_BITS'(v1y_s2);
		dy_v1x_s3  <= PROD_BITS'(RAY_DY) * PROD_BITS'(v1x_s2);
		v2x_v1y_s3 <= CPROD_BITS'(v2x_s2) * CPROD_BITS'(v1y_s2);
		v2y_v1x_s3 <= CPROD_BITS'(v2y_s2) * CPROD_BITS'(v1x_s2);
	end

	always_ff @(posedge clk) begin
		den_s4 <= LIN_BITS'(dx_v2y_s3) - LIN_BITS'(dy_v2x_s3);
		num_s4 <= LIN_BITS'(dx_v1y_s3) - LIN_BITS'(dy_v1x_s3);
		crs_s4 <= CRS_BITS'(v2x_v1y_s3) - CRS_BITS'(v2y_v1x_s3);
	end

	// strict 0 < t2 < 1 and t1 > 0, parallel edges rejected
	always_comb begin
		den_nz  = (den_s4 != '0);
		crs_nz  = (crs_s4 != '0);
		num_pos = !num_s4[LIN_BITS-1] && (num_s4 != '0);
		num_neg = num_s4[LIN_BITS-1];
		hit_d   = den_nz && crs_nz && (crs_s4[CRS_BITS-1] == den_s4[LIN_BITS-1]) &&
			(den_s4[LIN_BITS-1] ? (num_neg && (num_s4 > den_s4))
			                    : (num_pos && (num_s4 < den_s4)));
	end

	always_ff @(posedge clk) begin
		hit_s5 <= hit_d;
	end

	assign stat.busy      = v_s2 | v_s3 | v_s4 | v_s5;
	assign stat.hit_valid = v_s5;
	assign stat.hit       = hit_s5;

endmodule

### rtl/point_in_polygon_ray_parity.sv
// channel  | modport | transaction
// ---------+---------+------------------------------------------------------
// item     | sink    | cmd clear / add edge / query, edge and probe coords
// result   | source  | inside_res, crossings, edges_held, overflowed
//
// clear and add are taken in idle and give no result transaction.
// a query holds the input: one read of the edge memory per cycle, then the
// four-stage crossing pipeline drains, then the result state loads the
// parity, tally, edge count and overflow flag into the output register.
// the single read/write port of the edge memory sets the scan rate.
// a finished result sits in the output register, so the next item can be
// taken while the result waits; a second query then holds in its result cycle.
// reset clears edge count, overflow flag and control; the memory is not cleared.
module point_in_polygon_ray_parity
	import pipr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pipr_in_if.sink     item,
	pipr_out_if.source  result
);

	state_t state_q, state_d;

	// edge memory, one write or one read per cycle
	seg_t edge_mem [MAX_EDGES];
	seg_t rd_seg_s1;
	logic rd_valid_s1;

	logic [CNT_BITS-1:0] edge_count_q;
	logic                overflow_q;
	logic [CNT_BITS-1:0] rd_cnt_q;
	logic [CNT_BITS-1:0] hits_q;
	coord_t              px_q, py_q;

	logic accept, wr_en, rd_en, res_load, scan_done;
	cross_stat_t cross_stat;

	logic                out_valid_q;
	logic                out_inside_q;
	logic [CNT_BITS-1:0] out_cross_q;
	logic [CNT_BITS-1:0] out_held_q;
	logic                out_ovf_q;

	assign accept    = item.valid && item.ready;
	assign wr_en     = accept && (item.cmd == CMD_ADD) && (edge_count_q < CNT_BITS'(MAX_EDGES));
	assign scan_done = (rd_cnt_q >= edge_count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.cmd == CMD_QUERY))
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!rd_valid_s1 && !cross_stat.busy)
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || result.ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item.ready = 1'b0;
		rd_en      = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			ST_IDLE:   item.ready = 1'b1;
			ST_SCAN:   rd_en      = !scan_done;
			ST_FLUSH:  ;
			ST_RESULT: res_load   = !out_valid_q || result.ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// memory port: add writes at the fill count, a scan reads in order
	always_ff @(posedge clk) begin
		if (wr_en)
			edge_mem[edge_count_q[ADDR_BITS-1:0]] <= '{sx: item.start_x, sy: item.start_y,
				ex: item.end_x, ey: item.end_y};
		else if (rd_en)
			rd_seg_s1 <= edge_mem[rd_cnt_q[ADDR_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_valid_s1 <= 1'b0;
		else
			rd_valid_s1 <= rd_en;
	end

	// fill count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (accept && (item.cmd == CMD_CLEAR)) begin
			edge_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (accept && (item.cmd == CMD_ADD)) begin
			if (wr_en)
				edge_count_q <= edge_count_q + CNT_BITS'(1);
			else
				overflow_q <= 1'b1;
		end
	end

	// scan address and crossing tally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			hits_q   <= '0;
		end else begin
			if (accept && (item.cmd == CMD_QUERY)) begin
				rd_cnt_q <= '0;
				hits_q   <= '0;
			end else begin
				if (rd_en)
					rd_cnt_q <= rd_cnt_q + CNT_BITS'(1);
				if (cross_stat.hit_valid && cross_stat.hit)
					hits_q <= hits_q + CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.cmd == CMD_QUERY)) begin
			px_q <= item.probe_x;
			py_q <= item.probe_y;
		end
	end

	pipr_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (rd_valid_s1),
		.seg       (rd_seg_s1),
		.px        (px_q),
		.py        (py_q),
		.stat      (cross_stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_inside_q <= hits_q[0];
			out_cross_q  <= hits_q;
			out_held_q   <= edge_count_q;
			out_ovf_q    <= overflow_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.inside_res = out_inside_q;
	assign result.crossings  = out_cross_q;
	assign result.edges_held = out_held_q;
	assign result.overflowed = out_ovf_q;

`include "point_in_polygon_ray_parity_defines.svh"

	// nothing left in flight once back in idle
	`PIPR_CHECK(a_idle_drained, state_q == ST_IDLE, !rd_valid_s1 && !cross_stat.busy, "busy in idle")

	// a scan never counts more crossings than edges held
	`PIPR_CHECK(a_hits_bounded, state_q != ST_IDLE, hits_q <= edge_count_q, "tally above count")

	// an add below capacity grows the store by exactly one
	`PIPR_CHECK_NEXT(a_add_grows, wr_en, edge_count_q == $past(edge_count_q) + CNT_BITS'(1), "no grow")

endmodule

### verif/point_in_polygon_ray_parity_tb.sv
module point_in_polygon_ray_parity_tb;
	import pipr_pkg::*;

	localparam int ITEM_TARGET  = 1350;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 600;
	localparam int MAX_REPORTS  = 10;
	localparam int C_MAX        = 2 ** (COORD_BITS - 1) - 1;
	localparam int C_MIN        = -(2 ** (COORD_BITS - 1));

	// code outside the command range, the block drops it
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// an integer step along the ray direction: an edge with this
	// span is parallel to the ray, a probe offset by it sees the ray hit a vertex
	localparam int PAR_DX = 11585;
	localparam int PAR_DY = 14189;

	typedef struct packed {
		logic [1:0] cmd;
		seg_t       seg;
		coord_t     px;
		coord_t     py;
	} stim_t;

	typedef struct packed {
		logic                inside_res;
		logic [CNT_BITS-1:0] crossings;
		logic [CNT_BITS-1:0] edges_held;
		logic                overflowed;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	pipr_in_if  item_if ();
	pipr_out_if result_if ();

	point_in_polygon_ray_parity i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the edge store and its flags
	seg_t     shadow_edges [MAX_EDGES];
	int       shadow_count;
	bit       shadow_overflow;

	stim_t    pending_items [$];
	verdict_t expected_verdicts [$];

	// bookkeeping
	int planned_items;
	int cycle_count;
	int failures;
	int results_seen;
	int queries_taken;
	int adds_taken;
	int adds_dropped;
	int clears_taken;
	int overflow_queries;
	int deepest_store;

	// last generated polygon, used to aim probes
	int poly_x [64];
	int poly_y [64];
	int poly_n;
	int poly_cx;
	int poly_cy;
	int poly_span;

	function automatic int sign_of(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	// exact crossing test: den is the ray/edge determinant, num2 places
	// the hit along the edge, crs gives the side of the probe (ray t > 0)
	function automatic bit ray_hits_edge(seg_t e, coord_t px, coord_t py);
		longint v1x, v1y, v2x, v2y, den, num2, crs;
		v1x  = longint'($signed(px)) - longint'($signed(e.sx));
		v1y  = longint'($signed(py)) - longint'($signed(e.sy));
		v2x  = longint'($signed(e.ex)) - longint'($signed(e.sx));
		v2y  = longint'($signed(e.ey)) - longint'($signed(e.sy));
		den  = longint'(RAY_DX) * v2y - longint'(RAY_DY) * v2x;
		num2 = longint'(RAY_DX) * v1y - longint'(RAY_DY) * v1x;
		crs  = v2x * v1y - v2y * v1x;
		// parallel or degenerate edges never count
		if (den == 0)
			return 1'b0;
		if (crs == 0 || sign_of(crs) != sign_of(den))
			return 1'b0;
		// strict interior of the edge, endpoints excluded
		if (den > 0)
			return (num2 > 0) && (num2 < den);
		return (num2 < 0) && (num2 > den);
	endfunction

	// advance the shadow store by one accepted transaction
	function automatic void apply_item(stim_t it);
		int       hits;
		verdict_t v;
		hits = 0;
		case (it.cmd)
			CMD_CLEAR: begin
				shadow_count    = 0;
				shadow_overflow = 1'b0;
				clears_taken++;
			end
			CMD_ADD: begin
				adds_taken++;
				if (shadow_count >= MAX_EDGES) begin
					// full store: edge dropped, sticky flag set
					shadow_overflow = 1'b1;
					adds_dropped++;
				end else begin
					shadow_edges[shadow_count] = it.seg;
					shadow_count++;
					if (shadow_count > deepest_store)
						deepest_store = shadow_count;
				end
			end
			CMD_QUERY: begin
				for (int i = 0; i < shadow_count; i++)
					if (ray_hits_edge(shadow_edges[i], it.px, it.py))
						hits++;
				v.inside_res = hits[0];
				v.crossings  = CNT_BITS'(hits);
				v.edges_held = CNT_BITS'(shadow_count);
				v.overflowed = shadow_overflow;
				expected_verdicts = {expected_verdicts, v};
				queries_taken++;
				if (shadow_overflow)
					overflow_queries++;
			end
			default: begin
				// unused code, nothing changes
			end
		endcase
	endfunction

	// idle length, mostly short with a few long ones
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(80, 20);
	endfunction

	// random value around c, clipped to the coordinate range
	function automatic int near(int c, int span);
		int v;
		v = c + int'($urandom_range(2 * span)) - span;
		if (v > C_MAX)
			v = C_MAX;
		if (v < C_MIN)
			v = C_MIN;
		return v;
	endfunction

	task automatic push_item(logic [1:0] cmd, int sx, int sy, int ex, int ey,
		int px, int py);
		stim_t it;
		it.cmd    = cmd;
		it.seg.sx = coord_t'(sx);
		it.seg.sy = coord_t'(sy);
		it.seg.ex = coord_t'(ex);
		it.seg.ey = coord_t'(ey);
		it.px     = coord_t'(px);
		it.py     = coord_t'(py);
		pending_items = {pending_items, it};
		if (cmd != CMD_UNUSED)
			planned_items++;
	endtask

	// unused fields of each transaction carry random bits
	task automatic add_edge(int sx, int sy, int ex, int ey);
		push_item(CMD_ADD, sx, sy, ex, ey, $urandom, $urandom);
	endtask

	task automatic query(int px, int py);
		push_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, px, py);
	endtask

	task automatic clear_store();
		push_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// closed loop of n vertices; some edges axis aligned, parallel or degenerate
	task automatic make_polygon(int n, int span);
		int r;
		poly_n    = n;
		poly_span = span;
		poly_cx   = near(0, C_MAX);
		poly_cy   = near(0, C_MAX);
		for (int i = 0; i < n; i++) begin
			poly_x[i] = near(poly_cx, span);
			poly_y[i] = near(poly_cy, span);
			r = $urandom_range(99);
			if (i > 0) begin
				if (r < 10) begin
					poly_x[i] = poly_x[i-1];
				end else if (r < 20) begin
					poly_y[i] = poly_y[i-1];
				end else if (r < 24) begin
					poly_x[i] = near(poly_x[i-1] + PAR_DX, 0);
					poly_y[i] = near(poly_y[i-1] + PAR_DY, 0);
				end else if (r < 27) begin
					poly_x[i] = poly_x[i-1];
					poly_y[i] = poly_y[i-1];
				end
			end
		end
		for (int i = 0; i < n; i++)
			add_edge(poly_x[i], poly_y[i], poly_x[(i + 1) % n], poly_y[(i + 1) % n]);
	endtask

	// probe around the last polygon: interior area, vertices, edge midpoints,
	// rays through a vertex, points a ray step past a vertex, or anywhere
	task automatic query_near_polygon();
		int k, k2, r;
		k  = $urandom_range(poly_n - 1);
		k2 = (k + 1) % poly_n;
		r  = $urandom_range(99);
		if (r < 50)
			query(near(poly_cx, poly_span), near(poly_cy, poly_span));
		else if (r < 60)
			query(poly_x[k], poly_y[k]);
		else if (r < 70)
			query((poly_x[k] + poly_x[k2]) / 2, (poly_y[k] + poly_y[k2]) / 2);
		else if (r < 80)
			query(near(poly_x[k] - PAR_DX, 0), near(poly_y[k] - PAR_DY, 0));
		else if (r < 85)
			query(near(poly_x[k] + PAR_DX, 0), near(poly_y[k] + PAR_DY, 0));
		else
			query($urandom, $urandom);
	endtask

	// driver: one transaction offered at a time, held until ready
	stim_t cur_item;
	int    send_gap;
	bit    quiet_phase;

	// stretches with no idling on either side
	always @(posedge clk)
		quiet_phase <= ((cycle_count / 4000) % 5) == 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid   <= 1'b0;
			item_if.cmd     <= CMD_CLEAR;
			item_if.start_x <= '0;
			item_if.start_y <= '0;
			item_if.end_x   <= '0;
			item_if.end_y   <= '0;
			item_if.probe_x <= '0;
			item_if.probe_y <= '0;
			send_gap = 0;
		end else begin
			if (item_if.valid && item_if.ready)
				apply_item(cur_item);
			if (!item_if.valid || item_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_if.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					item_if.valid   <= 1'b1;
					item_if.cmd     <= cur_item.cmd;
					item_if.start_x <= cur_item.seg.sx;
					item_if.start_y <= cur_item.seg.sy;
					item_if.end_x   <= cur_item.seg.ex;
					item_if.end_y   <= cur_item.seg.ey;
					item_if.probe_x <= cur_item.px;
					item_if.probe_y <= cur_item.py;
					send_gap = pick_gap(quiet_phase);
				end else begin
					item_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transaction against the oldest expectation
	verdict_t got_verdict;
	verdict_t want_verdict;
	int       stall_left;
	int       hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got_verdict.inside_res = result_if.inside_res;
				got_verdict.crossings  = result_if.crossings;
				got_verdict.edges_held = result_if.edges_held;
				got_verdict.overflowed = result_if.overflowed;
				results_seen++;
				if (expected_verdicts.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("result %0d unexpected: inside %0b cross %0d held %0d ovf %0b",
							results_seen, got_verdict.inside_res, got_verdict.crossings,
							got_verdict.edges_held, got_verdict.overflowed);
				end else begin
					want_verdict = expected_verdicts.pop_front();
					if (got_verdict.inside_res !== want_verdict.inside_res ||
						got_verdict.crossings !== want_verdict.crossings ||
						got_verdict.edges_held !== want_verdict.edges_held ||
						got_verdict.overflowed !== want_verdict.overflowed) begin
						failures++;
						if (failures <= MAX_REPORTS) begin
							$display("result %0d mismatch: expected inside %0b cross %0d held %0d ovf %0b",
								results_seen, want_verdict.inside_res, want_verdict.crossings,
								want_verdict.edges_held, want_verdict.overflowed);
							$display("result %0d mismatch: got inside %0b cross %0d held %0d ovf %0b",
								results_seen, got_verdict.inside_res, got_verdict.crossings,
								got_verdict.edges_held, got_verdict.overflowed);
						end
					end
				end
				// long back-pressure so the output register and input fill up
				if (results_seen == 40 || results_seen == 300)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				stall_left = pick_gap(quiet_phase);
			end
		end
	end

	// watchdog, counted on the falling edge so clocked blocks read it cleanly
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(negedge clk);
			cycle_count++;
		end
		$display("watchdog expired after %0d cycles", cycle_count);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int r;
		int n;
		int span;
		int fills_done;

		// every input known from the first time step
		arst_n            = 1'b0;
		item_if.valid     = 1'b0;
		item_if.cmd       = CMD_CLEAR;
		item_if.start_x   = '0;
		item_if.start_y   = '0;
		item_if.end_x     = '0;
		item_if.end_y     = '0;
		item_if.probe_x   = '0;
		item_if.probe_y   = '0;
		result_if.ready   = 1'b0;
		shadow_count      = 0;
		shadow_overflow   = 1'b0;
		planned_items     = 0;
		failures          = 0;
		results_seen      = 0;
		queries_taken     = 0;
		adds_taken        = 0;
		adds_dropped      = 0;
		clears_taken      = 0;
		overflow_queries  = 0;
		deepest_store     = 0;
		poly_n            = 0;
		fills_done        = 0;

		// directed: empty store, coordinate extremes, degenerate and parallel
		// edges, a square probed inside, on a vertex, on an edge and with the
		// ray through a vertex, the unused code, and clears
		query(C_MIN, C_MAX);
		add_edge(C_MIN, C_MIN, C_MAX, C_MAX);
		add_edge(C_MAX, C_MIN, C_MIN, C_MAX);
		add_edge(5, 5, 5, 5);
		add_edge(0, 0, PAR_DX, PAR_DY);
		add_edge(-100, -100, 100, -100);
		add_edge(100, -100, 100, 100);
		add_edge(100, 100, -100, 100);
		add_edge(-100, 100, -100, -100);
		query(0, 0);
		query(100, 100);
		query(100, 0);
		query(-100 - PAR_DX, -100 - PAR_DY);
		query(C_MAX, C_MAX);
		query(C_MIN, C_MIN);
		query(0, C_MIN);
		push_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		query(-50, -50);
		clear_store();
		query(0, 0);
		clear_store();
		clear_store();
		query(C_MAX, C_MIN);

		// random: mostly polygons followed by probes, some noise, and two
		// passes that fill the store exactly and then overflow it
		while (planned_items < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (fills_done < 2 && planned_items > 450 * (fills_done + 1)) begin
				clear_store();
				for (int i = 0; i < MAX_EDGES; i++)
					add_edge(near(0, 3000), near(0, 3000), near(0, 3000), near(0, 3000));
				query(near(0, 3000), near(0, 3000));
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++)
					add_edge($urandom, $urandom, $urandom, $urandom);
				query(near(0, 3000), near(0, 3000));
				query($urandom, $urandom);
				clear_store();
				query(near(0, 3000), near(0, 3000));
				fills_done++;
			end else if (poly_n == 0 || r < 50) begin
				if ($urandom_range(9) < 8)
					clear_store();
				n = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(16, 3);
				case ($urandom_range(2))
					0: span = 100;
					1: span = 2000;
					default: span = C_MAX;
				endcase
				make_polygon(n, span);
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++)
					query_near_polygon();
			end else if (r < 82) begin
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++)
					query_near_polygon();
			end else begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					push_item(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every transaction to be taken and every result to come back
		while (pending_items.size() != 0 || item_if.valid || expected_verdicts.size() != 0)
			@(negedge clk);
		// a late or spurious result would show up here
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_verdicts.size() != 0) begin
			failures += expected_verdicts.size();
			$display("%0d expected results never arrived", expected_verdicts.size());
		end

		$display("checked %0d queries, %0d adds (%0d dropped when full), %0d clears",
			queries_taken, adds_taken, adds_dropped, clears_taken);
		$display("deepest store %0d edges, %0d queries with overflow set, %0d failures",
			deepest_store, overflow_queries, failures);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
